### hdl/nte_pkg.sv
// Package for the nested TLV group encoder: sizes, operation and status codes,
// and the result record. No dependencies.
`default_nettype none

package nte_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int MAX_NESTING  = 8;

    localparam int FILL_W    = $clog2(BUFFER_BYTES + 1);
    localparam int OFFSET_W  = $clog2(BUFFER_BYTES);
    localparam int DEPTH_W   = $clog2(MAX_NESTING + 1);
    localparam int STK_IDX_W = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int TAG_W    = 8;
    localparam int WADDR_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int GROUPS_W = 4;

    // up to five bytes per transaction: tag plus four length bytes
    localparam int BURST_BYTES = 5;
    localparam int BURST_W     = BURST_BYTES * BYTE_W;
    localparam int LEFT_W      = $clog2(BURST_BYTES + 1);
    localparam int LEN_BYTES   = 4;

    localparam logic [OP_W-1:0] OP_PUT_BYTE = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT_HALF = 3'd1;
    localparam logic [OP_W-1:0] OP_PUT_WORD = 3'd2;
    localparam logic [OP_W-1:0] OP_OPEN     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLOSE    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_GROUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BUF_FULL  = 2'd3;

    typedef struct packed {
        logic                write_enable;
        logic [WADDR_W-1:0]  write_address;
        logic [BYTE_W-1:0]   write_byte;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [GROUPS_W-1:0] groups_open;
    } t_result;

endpackage

`default_nettype wire

### hdl/nte_if.sv
// Valid/ready channel interfaces for the nested TLV group encoder.
// Depends on nte_pkg for field widths.
`default_nettype none

interface nte_item_if;
    logic                        valid;
    logic                        ready;
    logic [nte_pkg::OP_W-1:0]    operation;
    logic [nte_pkg::VALUE_W-1:0] value;
    logic [nte_pkg::TAG_W-1:0]   tag;

    modport source (output valid, output operation, output value, output tag, input ready);
    modport sink   (input valid, input operation, input value, input tag, output ready);
endinterface

interface nte_result_if;
    logic                         valid;
    logic                         ready;
    logic                         write_enable;
    logic [nte_pkg::WADDR_W-1:0]  write_address;
    logic [nte_pkg::BYTE_W-1:0]   write_byte;
    logic                         last;
    logic [nte_pkg::STATUS_W-1:0] status;
    logic [nte_pkg::GROUPS_W-1:0] groups_open;

    modport source (output valid, output write_enable, output write_address,
                    output write_byte, output last, output status,
                    output groups_open, input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_byte, input last, input status,
                    input groups_open, output ready);
endinterface

`default_nettype wire

### hdl/nested_tlv_group_encoder_unit.sv
// Nested TLV group encoder: turns byte, word and group transactions into byte writes.
// Path: an accepted transaction's results pass through the burst register and then the
// output register before they are valid on o_result.
// Throughput: one result per cycle while the output is not stalled; the burst register
// gives 1 result for a byte, an error or an ignored operation, else 2, 4 or 5.
// Reset (synchronous, active low) clears the fill pointer, group count and valids.
// Depends on nte_pkg and nte_if.
`default_nettype none

module nested_tlv_group_encoder_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    nte_item_if.sink   i_item,
    nte_result_if.source o_result
);
    import nte_pkg::*;

    // state
    logic [FILL_W-1:0]   r_fill;
    logic [DEPTH_W-1:0]  r_count;
    logic [OFFSET_W-1:0] r_stack [MAX_NESTING];

    // burst register: results of the transaction in progress
    logic                r_b_valid;
    logic [LEFT_W-1:0]   r_b_left;
    logic [WADDR_W-1:0]  r_b_addr;
    logic [BURST_W-1:0]  r_b_bytes;
    logic                r_b_we;
    logic [STATUS_W-1:0] r_b_status;
    logic [GROUPS_W-1:0] r_b_groups;

    // output register
    logic    r_o_valid;
    t_result r_o;

    logic b_advance, b_final, accept;

    logic [LEFT_W-1:0]    need_n;
    logic                 room;
    logic [STK_IDX_W-1:0] top_idx;
    logic [OFFSET_W-1:0]  top_base;
    logic [FILL_W-1:0]    len_value;
    logic [DEPTH_W-1:0]   count_dec;

    logic [LEFT_W-1:0]   n_left;
    logic [WADDR_W-1:0]  n_addr;
    logic [BURST_W-1:0]  n_bytes;
    logic                n_we;
    logic [STATUS_W-1:0] n_status;
    logic [FILL_W-1:0]   n_fill;
    logic [DEPTH_W-1:0]  n_count;
    logic                push;

    assign b_advance = r_b_valid && (!r_o_valid || o_result.ready);
    assign b_final   = (r_b_left == LEFT_W'(1));
    assign i_item.ready = !r_b_valid || (b_advance && b_final);
    assign accept    = i_item.valid && i_item.ready;

    always_comb begin
        case (i_item.operation)
            OP_PUT_BYTE: need_n = LEFT_W'(1);
            OP_PUT_HALF: need_n = LEFT_W'(2);
            OP_PUT_WORD: need_n = LEFT_W'(4);
            OP_OPEN:     need_n = LEFT_W'(BURST_BYTES);
            default:     need_n = LEFT_W'(LEN_BYTES);
        endcase
    end

    assign room       = ({1'b0, r_fill} + (FILL_W + 1)'(need_n)) <= (FILL_W + 1)'(BUFFER_BYTES);
    assign count_dec  = r_count - DEPTH_W'(1);
    assign top_idx    = count_dec[STK_IDX_W-1:0];
    assign top_base   = r_stack[top_idx];
    assign len_value  = r_fill - FILL_W'(top_base) - FILL_W'(LEN_BYTES);

    always_comb begin
        n_left   = LEFT_W'(1);
        n_addr   = '0;
        n_bytes  = '0;
        n_we     = 1'b0;
        n_status = ST_OK;
        n_fill   = r_fill;
        n_count  = r_count;
        push     = 1'b0;
        case (i_item.operation)
            OP_PUT_BYTE, OP_PUT_HALF, OP_PUT_WORD: begin
                if (!room) begin
                    n_status = ST_BUF_FULL;
                end else begin
                    n_we   = 1'b1;
                    n_left = need_n;
                    n_addr = WADDR_W'(r_fill);
                    n_fill = r_fill + FILL_W'(need_n);
                    // most significant byte leads
                    case (i_item.operation)
                        OP_PUT_BYTE: n_bytes = {i_item.value[7:0], 32'd0};
                        OP_PUT_HALF: n_bytes = {i_item.value[15:0], 24'd0};
                        default:     n_bytes = {i_item.value, 8'd0};
                    endcase
                end
            end
            OP_OPEN: begin
                if (r_count >= DEPTH_W'(MAX_NESTING)) begin
                    n_status = ST_NEST_FULL;
                end else if (!room) begin
                    n_status = ST_BUF_FULL;
                end else begin
                    n_we    = 1'b1;
                    n_left  = LEFT_W'(BURST_BYTES);
                    n_addr  = WADDR_W'(r_fill);
                    n_bytes = {i_item.tag, 32'd0};
                    n_fill  = r_fill + FILL_W'(BURST_BYTES);
                    n_count = r_count + DEPTH_W'(1);
                    push    = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (r_count == '0) begin
                    n_status = ST_NO_GROUP;
                end else begin
                    // backpatch the length field of the innermost group
                    n_we    = 1'b1;
                    n_left  = LEFT_W'(LEN_BYTES);
                    n_addr  = WADDR_W'(top_base);
                    n_bytes = {32'(len_value), 8'd0};
                    n_count = count_dec;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    // offset of the length field, just past the tag byte
    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_stack[r_count[STK_IDX_W-1:0]] <= OFFSET_W'(r_fill + FILL_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_advance && b_final) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_left   <= n_left;
            r_b_addr   <= n_addr;
            r_b_bytes  <= n_bytes;
            r_b_we     <= n_we;
            r_b_status <= n_status;
            r_b_groups <= GROUPS_W'(n_count);
        end else if (b_advance) begin
            r_b_left  <= r_b_left - LEFT_W'(1);
            r_b_addr  <= r_b_addr + WADDR_W'(1);
            r_b_bytes <= {r_b_bytes[BURST_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_advance) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance) begin
            r_o.write_enable  <= r_b_we;
            r_o.write_address <= r_b_addr;
            r_o.write_byte    <= r_b_bytes[BURST_W-1 -: BYTE_W];
            r_o.last          <= b_final;
            r_o.status        <= r_b_status;
            r_o.groups_open   <= r_b_groups;
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.write_enable  = r_o.write_enable;
    assign o_result.write_address = r_o.write_address;
    assign o_result.write_byte    = r_o.write_byte;
    assign o_result.last          = r_o.last;
    assign o_result.status        = r_o.status;
    assign o_result.groups_open   = r_o.groups_open;

    // an error transaction writes nothing and ends at once
    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o.status != ST_OK) |-> (!r_o.write_enable && r_o.last))
        else $error("error result carries a write");

    // no new transaction while a multi-byte burst still has more than one result
    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_final) |-> !i_item.ready)
        else $error("input accepted during a burst");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(BUFFER_BYTES)) && (r_count <= DEPTH_W'(MAX_NESTING)))
        else $error("fill pointer or group count out of range");

    // a burst only drains while it can move into the output register
    a_drain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_o_valid && !o_result.ready && !accept) |=>
            (r_b_valid && $stable(r_b_left)))
        else $error("burst advanced into a stalled output");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Testbench for nested_tlv_group_encoder_unit: drives byte, word and group transactions
// and checks every byte write against a predictor of the message buffer and group stack.
// Depends on nte_pkg, nte_if and the encoder RTL.
`timescale 1ns / 100ps

module tb;
    import nte_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 300;
    localparam int MAX_REPORTS = 10;

    // Tracks fill pointer and open-group offsets; queues the writes each transaction causes.
    class tlv_write_tracker;
        logic [FILL_W-1:0]   fill;
        logic [OFFSET_W-1:0] len_offset [MAX_NESTING];
        logic [DEPTH_W-1:0]  depth;
        t_result             expected_writes [$];
        t_result             staged [$];
        int                  mismatches;

        function new();
            fill = '0;
            depth = '0;
            mismatches = 0;
        endfunction

        function void stage_write(logic [WADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
            t_result r;
            r = '0;
            r.write_enable = 1'b1;
            r.write_address = addr;
            r.write_byte = data;
            r.status = ST_OK;
            staged.insert(staged.size(), r);
        endfunction

        // no write: error codes and ignored operations
        function void stage_status(logic [STATUS_W-1:0] st);
            t_result r;
            r = '0;
            r.status = st;
            staged.insert(staged.size(), r);
        endfunction

        // append the low bytes of word, most significant first
        function void append_bytes(logic [VALUE_W-1:0] word, int count);
            for (int i = count - 1; i >= 0; i--) begin
                stage_write(fill[WADDR_W-1:0], word[8*i +: 8]);
                fill = fill + 1'b1;
            end
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                logic [TAG_W-1:0] tag);
            int                  width_bytes;
            logic [31:0]         size;
            logic [OFFSET_W-1:0] base;
            t_result             r;
            staged.delete();
            case (op)
                OP_PUT_BYTE, OP_PUT_HALF, OP_PUT_WORD: begin
                    width_bytes = (op == OP_PUT_BYTE) ? 1 : (op == OP_PUT_HALF) ? 2 : 4;
                    if (int'(fill) + width_bytes > BUFFER_BYTES)
                        stage_status(ST_BUF_FULL);
                    else
                        append_bytes(value, width_bytes);
                end
                OP_OPEN: begin
                    // nesting limit takes priority over buffer room
                    if (depth >= MAX_NESTING) begin
                        stage_status(ST_NEST_FULL);
                    end else if (int'(fill) + 1 + LEN_BYTES > BUFFER_BYTES) begin
                        stage_status(ST_BUF_FULL);
                    end else begin
                        append_bytes(VALUE_W'(tag), 1);
                        len_offset[depth] = fill[OFFSET_W-1:0];
                        depth = depth + 1'b1;
                        append_bytes('0, LEN_BYTES);
                    end
                end
                OP_CLOSE: begin
                    if (depth == 0) begin
                        stage_status(ST_NO_GROUP);
                    end else begin
                        depth = depth - 1'b1;
                        base = len_offset[depth];
                        size = 32'(fill) - 32'(base) - LEN_BYTES;
                        for (int i = 0; i < LEN_BYTES; i++)
                            stage_write(WADDR_W'(32'(base) + i),
                                        size[8*(LEN_BYTES-1-i) +: 8]);
                    end
                end
                default: stage_status(ST_OK);
            endcase
            foreach (staged[k]) begin
                r = staged[k];
                r.groups_open = GROUPS_W'(depth);
                r.last = (k == staged.size() - 1);
                expected_writes.insert(expected_writes.size(), r);
            end
        endfunction

        function string describe(t_result r);
            return $sformatf("we=%0d addr=%03h byte=%02h last=%0d status=%0d groups=%0d",
                             r.write_enable, r.write_address, r.write_byte, r.last,
                             r.status, r.groups_open);
        endfunction

        function void check_write(t_result got);
            t_result want;
            if (expected_writes.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("Unexpected result: got %s", describe(got));
                mismatches++;
                return;
            end
            want = expected_writes.pop_front();
            if (got.write_enable !== want.write_enable ||
                got.write_address !== want.write_address ||
                got.write_byte !== want.write_byte ||
                got.last !== want.last ||
                got.status !== want.status ||
                got.groups_open !== want.groups_open) begin
                if (mismatches < MAX_REPORTS)
                    $display("Result mismatch: expected %s, got %s",
                             describe(want), describe(got));
                mismatches++;
            end
        endfunction
    endclass

    bit   clk;
    logic rst_n;

    nte_item_if   item_ch ();
    nte_result_if result_ch ();

    nested_tlv_group_encoder_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    tlv_write_tracker tracker = new();

    int   items_sent = 0;
    int   results_seen = 0;
    int   cycle_count = 0;
    int   tx_max = 5;
    int   rx_max = 5;
    int   rx_wait = 0;
    logic hold_off = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one transaction after a random gap; return at the falling edge after acceptance.
    task automatic send_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                             logic [TAG_W-1:0] tag);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.value     <= value;
        item_ch.tag       <= tag;
        do @(posedge clk); while (!item_ch.ready);
        tracker.note_item(op, value, tag);
        items_sent++;
        if (items_sent % 32 == 0)
            tx_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
        @(negedge clk);
    endtask

    // Mostly well-formed nesting with random content; occasional misuse.
    task automatic send_random_item();
        logic [OP_W-1:0] op;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_PUT_BYTE;
        else if (pick < 55)
            op = OP_PUT_HALF;
        else if (pick < 70)
            op = OP_PUT_WORD;
        else if (pick < 84)
            op = OP_OPEN;
        else if (pick < 97)
            op = OP_CLOSE;
        else
            op = OP_CLOSE + 3'($urandom_range(1, 3));
        if (op == OP_CLOSE && tracker.depth == 0 && $urandom_range(0, 3) != 0)
            op = OP_OPEN;
        if (op == OP_OPEN && tracker.depth == MAX_NESTING && $urandom_range(0, 3) != 0)
            op = OP_CLOSE;
        send_item(op, $urandom(), 8'($urandom()));
    endtask

    initial begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.operation = '0;
        item_ch.value = '0;
        item_ch.tag = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // nest to the limit, overflow the stack, write extremes, unwind past empty
        for (int i = 0; i < MAX_NESTING; i++)
            send_item(OP_OPEN, $urandom(),
                      (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom()));
        send_item(OP_OPEN, '0, 8'ha5);
        send_item(OP_PUT_BYTE, 32'hffff_ffff, '0);
        send_item(OP_PUT_HALF, 32'h0000_ffff, '0);
        send_item(OP_PUT_WORD, 32'hffff_ffff, 8'hff);
        send_item(OP_PUT_WORD, '0, '0);
        for (int i = 0; i <= MAX_NESTING; i++)
            send_item(OP_CLOSE, $urandom(), 8'($urandom()));
        for (int c = 1; c <= 3; c++)
            send_item(OP_CLOSE + 3'(c), 32'hffff_ffff, 8'hff);

        repeat (RANDOM_ITEMS) send_random_item();

        // close everything, then keep a few groups open across the fill so sizes get large
        while (tracker.depth != 0)
            send_item(OP_CLOSE, $urandom(), 8'($urandom()));
        repeat (3) send_item(OP_OPEN, $urandom(), 8'($urandom()));
        while (int'(tracker.fill) + 4 <= BUFFER_BYTES - 8)
            send_item(($urandom_range(0, 15) == 0) ? OP_PUT_HALF : OP_PUT_WORD,
                      $urandom(), 8'($urandom()));
        while (int'(tracker.fill) < BUFFER_BYTES - 8)
            send_item(OP_PUT_BYTE, $urandom(), 8'($urandom()));

        // walk the buffer to exactly full, hitting the room check on every kind
        send_item(OP_OPEN, $urandom(), 8'($urandom()));
        send_item(OP_PUT_WORD, $urandom(), 8'($urandom()));
        send_item(OP_OPEN, $urandom(), 8'($urandom()));
        send_item(OP_PUT_HALF, $urandom(), 8'($urandom()));
        send_item(OP_PUT_HALF, $urandom(), 8'($urandom()));
        send_item(OP_PUT_BYTE, $urandom(), 8'($urandom()));
        send_item(OP_PUT_BYTE, $urandom(), 8'($urandom()));
        send_item(OP_CLOSE + 3'd1, $urandom(), 8'($urandom()));
        while (tracker.depth != 0)
            send_item(OP_CLOSE, $urandom(), 8'($urandom()));
        send_item(OP_CLOSE, $urandom(), 8'($urandom()));
        item_ch.valid <= 1'b0;

        while (tracker.expected_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_writes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: random wait after each result, plus the long hold-off.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!rst_n || hold_off || rx_wait > 0) begin
                result_ch.ready <= 1'b0;
                if (rx_wait > 0)
                    rx_wait--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            tracker.check_write('{result_ch.write_enable, result_ch.write_address,
                                  result_ch.write_byte, result_ch.last,
                                  result_ch.status, result_ch.groups_open});
            results_seen++;
            if (results_seen % 48 == 0)
                rx_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            rx_wait = $urandom_range(0, rx_max);
        end
    end

    // Stall the output long enough that the encoder backs up into its input.
    initial begin
        wait (items_sent >= 60);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule
